// ===== src/sio_cfg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Super I/O configuration register file.
// No dependencies; imported by sio_cfg_regs, sio_cfg_decode and the top level.
package sio_cfg_pkg;

    // Register indexes behind the data port
    localparam logic [7:0] IDX_ID        = 8'h00;
    localparam logic [7:0] IDX_REV       = 8'h01;
    localparam logic [7:0] IDX_GEN1      = 8'h02;
    localparam logic [7:0] IDX_GEN2      = 8'h03;
    localparam logic [7:0] IDX_FDC1      = 8'h10;
    localparam logic [7:0] IDX_FDC2      = 8'h11;
    localparam logic [7:0] IDX_LPT1      = 8'h20;
    localparam logic [7:0] IDX_LPT2      = 8'h21;
    localparam logic [7:0] IDX_UARTA1    = 8'h30;
    localparam logic [7:0] IDX_UARTA2    = 8'h31;
    localparam logic [7:0] IDX_UARTB1    = 8'h40;
    localparam logic [7:0] IDX_UARTB2    = 8'h41;
    localparam logic [7:0] IDX_DISK      = 8'h50;

    localparam logic [7:0] ID_VALUE      = 8'ha0;
    localparam logic [7:0] REV_VALUE     = 8'h00;
    localparam logic [7:0] UNKNOWN_VALUE = 8'hff;

    // Write masks (writable bits) and kept read-only bits
    localparam logic [7:0] GEN1_WMASK  = 8'hb1;
    localparam logic [7:0] GEN1_KEEP   = 8'h48;
    localparam logic [7:0] GEN2_WMASK  = 8'hf8;
    localparam logic [7:0] FDC1_WMASK  = 8'h83;
    localparam logic [7:0] FDC2_WMASK  = 8'h0d;
    localparam logic [7:0] FDC2_KEEP   = 8'h02;
    localparam logic [7:0] LPT1_WMASK  = 8'hef;
    localparam logic [7:0] LPT2_WMASK  = 8'h0d;
    localparam logic [7:0] LPT2_KEEP   = 8'h22;
    localparam logic [7:0] UART1_WMASK = 8'h9f;
    localparam logic [7:0] UART2_WMASK = 8'h1d;
    localparam logic [7:0] UART2_KEEP  = 8'h02;
    localparam logic [7:0] DISK_WMASK  = 8'h07;

    // Decoded parallel-port bases by address code
    localparam logic [9:0] LPT_BASE0 = 10'h378;
    localparam logic [9:0] LPT_BASE1 = 10'h278;
    localparam logic [9:0] LPT_BASE2 = 10'h3bc;
    localparam logic [1:0] LPT_CODE_RSVD = 2'd3;

    localparam logic [2:0] IRQ_LOW  = 3'd3;
    localparam logic [2:0] IRQ_HIGH = 3'd4;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    typedef struct packed {
        logic       op;
        logic       port_select;
        logic [7:0] write_data;
    } access_t;

    typedef struct packed {
        logic [7:0] index_reg;
        logic [7:0] general_cfg1;
        logic [7:0] general_cfg2;
        logic [7:0] floppy_cfg1;
        logic [7:0] floppy_cfg2;
        logic [7:0] parallel_cfg1;
        logic [7:0] parallel_cfg2;
        logic [7:0] uart_a_cfg1;
        logic [7:0] uart_a_cfg2;
        logic [7:0] uart_b_cfg1;
        logic [7:0] uart_b_cfg2;
        logic [7:0] disk_cfg;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        index_reg:     8'h00,
        general_cfg1:  8'h40,
        general_cfg2:  8'h00,
        floppy_cfg1:   8'h01,
        floppy_cfg2:   8'h00,
        parallel_cfg1: 8'h00,
        parallel_cfg2: 8'h00,
        uart_a_cfg1:   8'h00,
        uart_a_cfg2:   8'h02,
        uart_b_cfg1:   8'h00,
        uart_b_cfg2:   8'h02,
        disk_cfg:      8'h01
    };

    typedef struct packed {
        logic       floppy_on;
        logic       parallel_on;
        logic [9:0] parallel_base;
        logic       uart_a_on;
        logic [9:0] uart_a_base;
        logic [2:0] uart_a_irq;
        logic       uart_b_on;
        logic [9:0] uart_b_base;
        logic [2:0] uart_b_irq;
    } decoded_t;

    function automatic logic [9:0] uart_base(input logic [2:0] sel);
        logic [9:0] b;
        case (sel)
            3'd0:    b = 10'h3f8;
            3'd1:    b = 10'h2f8;
            3'd2:    b = 10'h220;
            3'd3:    b = 10'h228;
            3'd4:    b = 10'h238;
            3'd5:    b = 10'h2e8;
            3'd6:    b = 10'h338;
            default: b = 10'h3e8;
        endcase
        return b;
    endfunction

endpackage

// ===== src/sio_cfg_regs.sv =====
`timescale 1ns / 1ps
// Index register and configuration registers with masked update and read mux.
// Depends on sio_cfg_pkg.
module sio_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  sio_cfg_pkg::access_t   acc,
    output sio_cfg_pkg::cfg_regs_t cfg_next,
    output logic [7:0]             read_data
);
    import sio_cfg_pkg::*;

    cfg_regs_t cfg_reg;
    logic      is_wr;
    logic [7:0] d;

    assign is_wr = (acc.op == OP_WRITE);
    assign d     = acc.write_data;

    // Post-access register contents
    always_comb
    begin
        cfg_next = cfg_reg;
        if (is_wr && acc.port_select == PORT_INDEX)
        begin
            cfg_next.index_reg = d;
        end
        else if (is_wr)
        begin
            case (cfg_reg.index_reg)
                IDX_GEN1:   cfg_next.general_cfg1 =
                                (d & GEN1_WMASK) | (cfg_reg.general_cfg1 & GEN1_KEEP);
                IDX_GEN2:   cfg_next.general_cfg2 = d & GEN2_WMASK;
                IDX_FDC1:   cfg_next.floppy_cfg1 = d & FDC1_WMASK;
                IDX_FDC2:   cfg_next.floppy_cfg2 =
                                (d & FDC2_WMASK) | (cfg_reg.floppy_cfg2 & FDC2_KEEP);
                IDX_LPT1:   cfg_next.parallel_cfg1 = d & LPT1_WMASK;
                IDX_LPT2:   cfg_next.parallel_cfg2 =
                                (d & LPT2_WMASK) | (cfg_reg.parallel_cfg2 & LPT2_KEEP);
                IDX_UARTA1: cfg_next.uart_a_cfg1 = d & UART1_WMASK;
                IDX_UARTA2: cfg_next.uart_a_cfg2 =
                                (d & UART2_WMASK) | (cfg_reg.uart_a_cfg2 & UART2_KEEP);
                IDX_UARTB1: cfg_next.uart_b_cfg1 = d & UART1_WMASK;
                IDX_UARTB2: cfg_next.uart_b_cfg2 =
                                (d & UART2_WMASK) | (cfg_reg.uart_b_cfg2 & UART2_KEEP);
                IDX_DISK:   cfg_next.disk_cfg = d & DISK_WMASK;
                default:    ; // ID, revision and unknown indexes ignore writes
            endcase
        end
    end

    // Read back from the post-access contents
    always_comb
    begin
        if (acc.port_select == PORT_INDEX)
        begin
            read_data = cfg_next.index_reg;
        end
        else
        begin
            case (cfg_next.index_reg)
                IDX_ID:     read_data = ID_VALUE;
                IDX_REV:    read_data = REV_VALUE;
                IDX_GEN1:   read_data = cfg_next.general_cfg1;
                IDX_GEN2:   read_data = cfg_next.general_cfg2;
                IDX_FDC1:   read_data = cfg_next.floppy_cfg1;
                IDX_FDC2:   read_data = cfg_next.floppy_cfg2;
                IDX_LPT1:   read_data = cfg_next.parallel_cfg1;
                IDX_LPT2:   read_data = cfg_next.parallel_cfg2;
                IDX_UARTA1: read_data = cfg_next.uart_a_cfg1;
                IDX_UARTA2: read_data = cfg_next.uart_a_cfg2;
                IDX_UARTB1: read_data = cfg_next.uart_b_cfg1;
                IDX_UARTB2: read_data = cfg_next.uart_b_cfg2;
                IDX_DISK:   read_data = cfg_next.disk_cfg;
                default:    read_data = UNKNOWN_VALUE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (en)
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/sio_cfg_decode.sv =====
`timescale 1ns / 1ps
// Decodes floppy, parallel-port and serial-port settings from register contents.
// Depends on sio_cfg_pkg.
module sio_cfg_decode (
    input  sio_cfg_pkg::cfg_regs_t cfg,
    output sio_cfg_pkg::decoded_t  dec
);
    import sio_cfg_pkg::*;

    logic [1:0] pcode;
    logic       lpt_on;

    assign pcode  = cfg.parallel_cfg1[2:1];
    assign lpt_on = cfg.parallel_cfg1[0] && (pcode != LPT_CODE_RSVD);

    always_comb
    begin
        dec.floppy_on   = cfg.floppy_cfg1[0] & ~cfg.floppy_cfg1[1];
        dec.parallel_on = lpt_on;
        if (!lpt_on)
        begin
            dec.parallel_base = '0;
        end
        else
        begin
            case (pcode)
                2'd0:    dec.parallel_base = LPT_BASE0;
                2'd1:    dec.parallel_base = LPT_BASE1;
                default: dec.parallel_base = LPT_BASE2;
            endcase
        end

        dec.uart_a_on   = cfg.uart_a_cfg1[0];
        dec.uart_a_base = cfg.uart_a_cfg1[0] ? uart_base(cfg.uart_a_cfg1[3:1]) : '0;
        dec.uart_a_irq  = !cfg.uart_a_cfg1[0] ? 3'd0 :
                          (cfg.uart_a_cfg1[4] ? IRQ_HIGH : IRQ_LOW);

        dec.uart_b_on   = cfg.uart_b_cfg1[0];
        dec.uart_b_base = cfg.uart_b_cfg1[0] ? uart_base(cfg.uart_b_cfg1[3:1]) : '0;
        dec.uart_b_irq  = !cfg.uart_b_cfg1[0] ? 3'd0 :
                          (cfg.uart_b_cfg1[4] ? IRQ_HIGH : IRQ_LOW);
    end

endmodule

// ===== src/superio_config_register_file.sv =====
`timescale 1ns / 1ps
// Top level of the Super I/O configuration register file: input register,
// register update/decode, result register. Depends on sio_cfg_pkg,
// sio_cfg_regs and sio_cfg_decode.
// Usage:
//   Slave stream (s_axis_*) carries one bus access per transaction:
//   tuser[0] = op (0 read, 1 write), tuser[1] = port select (0 index,
//   1 data), tdata = write byte. A write to the index port loads the index;
//   a write to the data port updates the indexed register through its
//   write mask. Each access yields exactly one master transaction
//   (m_axis_*) with the read byte and the decoded floppy, parallel and
//   serial-port settings as they stand after the access.
//   Path: an accepted access waits in the input register; the register
//   update, read mux and decode run between it and the result register.
//   Throughput: one transaction per cycle while m_axis_tready stays high,
//   set by the register update that each access completes as it advances
//   (each access sees the state left by the previous one).
//   Reset (rst_n low, asynchronous) empties both stages and returns all
//   configuration registers to their defaults.
//   When m_axis_tready is low the result holds; the input register still
//   takes one more access, after which s_axis_tready drops.
module superio_config_register_file (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] write_data
    input  logic [1:0]  s_axis_tuser,  // [0] op, [1] port_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] floppy_on, [9] parallel_on, [19:10] parallel_base,
    // [20] uart_a_on, [30:21] uart_a_base, [33:31] uart_a_irq,
    // [34] uart_b_on, [44:35] uart_b_base, [47:45] uart_b_irq
    output logic [47:0] m_axis_tdata
);
    import sio_cfg_pkg::*;

    // Input stage
    logic      in_valid_reg;
    logic      in_valid_next;
    access_t   in_acc_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [47:0] out_data_reg;
    logic [47:0] out_data_next;

    logic      advance;   // access moves from input to result register
    logic      s_fire;
    cfg_regs_t cfg_next;
    logic [7:0] rd_data;
    decoded_t  dec;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    sio_cfg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .acc       (in_acc_reg),
        .cfg_next  (cfg_next),
        .read_data (rd_data)
    );

    sio_cfg_decode u_decode (
        .cfg (cfg_next),
        .dec (dec)
    );

    assign out_data_next = {dec.uart_b_irq, dec.uart_b_base, dec.uart_b_on,
                            dec.uart_a_irq, dec.uart_a_base, dec.uart_a_on,
                            dec.parallel_base, dec.parallel_on, dec.floppy_on,
                            rd_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_acc_reg <= '{op: s_axis_tuser[0], port_select: s_axis_tuser[1],
                            write_data: s_axis_tdata};
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A new result only appears when an access leaves the input stage
    a_rise_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(advance))
        else $error("result appeared without an advancing access");

    // Input stage must free up whenever it is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // An enabled parallel port always has a nonzero base
    a_lpt_base: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tdata[19:10] != 10'd0))
        else $error("parallel port on with zero base");

    // A disabled serial port A reports no base and no interrupt
    a_uart_a_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[20])
            |-> (m_axis_tdata[30:21] == 10'd0 && m_axis_tdata[33:31] == 3'd0))
        else $error("serial port A off but base or irq set");

endmodule

// ===== verif/superio_config_register_file_tb.sv =====
`timescale 1ns / 1ps
// Testbench for superio_config_register_file: index/data port accesses in, one
// decoded status transaction out per access, checked against a local predictor.
// Depends on sio_cfg_pkg (indexes and access codes) and the superio_config_register_file RTL.
module superio_config_register_file_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int TOTAL_ITEMS    = 1050;

    // Register map as seen through the data port
    localparam logic [7:0] IX_ID   = sio_cfg_pkg::IDX_ID;
    localparam logic [7:0] IX_REV  = sio_cfg_pkg::IDX_REV;
    localparam logic [7:0] IX_GEN1 = sio_cfg_pkg::IDX_GEN1;
    localparam logic [7:0] IX_GEN2 = sio_cfg_pkg::IDX_GEN2;
    localparam logic [7:0] IX_FDC1 = sio_cfg_pkg::IDX_FDC1;
    localparam logic [7:0] IX_FDC2 = sio_cfg_pkg::IDX_FDC2;
    localparam logic [7:0] IX_LPT1 = sio_cfg_pkg::IDX_LPT1;
    localparam logic [7:0] IX_LPT2 = sio_cfg_pkg::IDX_LPT2;
    localparam logic [7:0] IX_UA1  = sio_cfg_pkg::IDX_UARTA1;
    localparam logic [7:0] IX_UA2  = sio_cfg_pkg::IDX_UARTA2;
    localparam logic [7:0] IX_UB1  = sio_cfg_pkg::IDX_UARTB1;
    localparam logic [7:0] IX_UB2  = sio_cfg_pkg::IDX_UARTB2;
    localparam logic [7:0] IX_DISK = sio_cfg_pkg::IDX_DISK;

    localparam logic [7:0] ID_BYTE       = 8'ha0;
    localparam logic [7:0] REV_BYTE      = 8'h00;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hff;
    localparam logic [1:0] LPT_RESERVED  = sio_cfg_pkg::LPT_CODE_RSVD;

    typedef struct packed {
        logic [7:0] read_data;
        logic       floppy_on;
        logic       parallel_on;
        logic [9:0] parallel_base;
        logic       uart_a_on;
        logic [9:0] uart_a_base;
        logic [2:0] uart_a_irq;
        logic       uart_b_on;
        logic [9:0] uart_b_base;
        logic [2:0] uart_b_irq;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] write_data
    logic [1:0]  s_axis_tuser = 2'b00;  // [0] op, [1] port_select
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] read_data, [8] floppy_on, [9] parallel_on, [19:10] parallel_base,
    // [20] uart_a_on, [30:21] uart_a_base, [33:31] uart_a_irq,
    // [34] uart_b_on, [44:35] uart_b_base, [47:45] uart_b_irq
    logic [47:0] m_axis_tdata;

    superio_config_register_file uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Predicted register contents
    logic [7:0] sel_index;
    logic [7:0] r_gen1, r_gen2, r_fdc1, r_fdc2, r_lpt1, r_lpt2;
    logic [7:0] r_ua1, r_ua2, r_ub1, r_ub2, r_disk;

    status_t pending_status[$];   // predicted status, oldest first
    int      mismatch_count = 0;
    int      accesses_sent  = 0;
    int      quiet_cycles   = 0;
    int      stall_left     = 0;
    bit      idle_on        = 1'b1;
    status_t want_status, got_status;

    task automatic reset_model();
        sel_index = 8'h00;
        r_gen1 = 8'h40;
        r_gen2 = 8'h00;
        r_fdc1 = 8'h01;
        r_fdc2 = 8'h00;
        r_lpt1 = 8'h00;
        r_lpt2 = 8'h00;
        r_ua1  = 8'h00;
        r_ua2  = 8'h02;
        r_ub1  = 8'h00;
        r_ub2  = 8'h02;
        r_disk = 8'h01;
    endtask

    function automatic logic [7:0] indexed_value(input logic [7:0] idx);
        case (idx)
            IX_ID:   return ID_BYTE;
            IX_REV:  return REV_BYTE;
            IX_GEN1: return r_gen1;
            IX_GEN2: return r_gen2;
            IX_FDC1: return r_fdc1;
            IX_FDC2: return r_fdc2;
            IX_LPT1: return r_lpt1;
            IX_LPT2: return r_lpt2;
            IX_UA1:  return r_ua1;
            IX_UA2:  return r_ua2;
            IX_UB1:  return r_ub1;
            IX_UB2:  return r_ub2;
            IX_DISK: return r_disk;
            default: return UNMAPPED_BYTE;
        endcase
    endfunction

    task automatic decode_serial(input logic [7:0] cfg, output logic on,
                                 output logic [9:0] base, output logic [2:0] irq);
        on   = cfg[0];
        base = 10'h000;
        irq  = 3'd0;
        if (cfg[0])
        begin
            case (cfg[3:1])
                3'd0:    base = 10'h3f8;
                3'd1:    base = 10'h2f8;
                3'd2:    base = 10'h220;
                3'd3:    base = 10'h228;
                3'd4:    base = 10'h238;
                3'd5:    base = 10'h2e8;
                3'd6:    base = 10'h338;
                default: base = 10'h3e8;
            endcase
            irq = cfg[4] ? 3'd4 : 3'd3;
        end
    endtask

    // Apply one access to the predicted registers and return the status
    // that the block reports after it.
    task automatic predict_access(input logic op, input logic port,
                                  input logic [7:0] d, output status_t res);
        logic [1:0] lpt_code;
        if (op == sio_cfg_pkg::OP_WRITE)
        begin
            if (port == sio_cfg_pkg::PORT_INDEX)
                sel_index = d;
            else
            begin
                // read-only bits keep their old value; ID, revision and
                // unmapped indexes swallow the write
                case (sel_index)
                    IX_GEN1: r_gen1 = (d & 8'hb1) | (r_gen1 & 8'h48);
                    IX_GEN2: r_gen2 = d & 8'hf8;
                    IX_FDC1: r_fdc1 = d & 8'h83;
                    IX_FDC2: r_fdc2 = (d & 8'h0d) | (r_fdc2 & 8'h02);
                    IX_LPT1: r_lpt1 = d & 8'hef;
                    IX_LPT2: r_lpt2 = (d & 8'h0d) | (r_lpt2 & 8'h22);
                    IX_UA1:  r_ua1  = d & 8'h9f;
                    IX_UA2:  r_ua2  = (d & 8'h1d) | (r_ua2 & 8'h02);
                    IX_UB1:  r_ub1  = d & 8'h9f;
                    IX_UB2:  r_ub2  = (d & 8'h1d) | (r_ub2 & 8'h02);
                    IX_DISK: r_disk = d & 8'h07;
                    default: ;
                endcase
            end
        end

        res.read_data = (port == sio_cfg_pkg::PORT_DATA) ? indexed_value(sel_index)
                                                        : sel_index;
        // floppy is on only at its primary address
        res.floppy_on = r_fdc1[0] & ~r_fdc1[1];

        lpt_code = r_lpt1[2:1];
        res.parallel_on   = 1'b0;
        res.parallel_base = 10'h000;
        if (r_lpt1[0] && lpt_code != LPT_RESERVED)
        begin
            res.parallel_on   = 1'b1;
            res.parallel_base = (lpt_code == 2'd0) ? 10'h378 :
                                (lpt_code == 2'd1) ? 10'h278 : 10'h3bc;
        end

        decode_serial(r_ua1, res.uart_a_on, res.uart_a_base, res.uart_a_irq);
        decode_serial(r_ub1, res.uart_b_on, res.uart_b_base, res.uart_b_irq);
    endtask

    // One access on the slave side; the prediction is taken at the accepting
    // edge so it follows the block's own order. tvalid stays high into the
    // next call unless an idle burst is drawn.
    task automatic send_access(input logic op, input logic port, input logic [7:0] d);
        status_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {port, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_access(op, port, d, res);
        pending_status.push_back(res);
        accesses_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [9:0] want,
                                 input logic [9:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ---------------------------------------------------------------- tests

    // ID and revision: read-only, writes ignored; index port readback
    task automatic test_id_and_revision();
        send_access(sio_cfg_pkg::OP_READ,  sio_cfg_pkg::PORT_INDEX, 8'h00);
        send_access(sio_cfg_pkg::OP_READ,  sio_cfg_pkg::PORT_DATA,  8'h00);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'hff);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_REV);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'hff);
    endtask

    // Unmapped index reads all ones and drops writes
    task automatic test_unknown_index();
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, 8'hff);
        send_access(sio_cfg_pkg::OP_READ,  sio_cfg_pkg::PORT_DATA,  8'h00);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h00);
    endtask

    // Parallel port: reserved address code reads as off, then code 2, then reserved again
    task automatic test_parallel_decode();
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_LPT1);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h07);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h05);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'hff);
    endtask

    // Serial ports; a config-2 write to the second port must not touch the first
    task automatic test_serial_ports();
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_UB2);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'hff);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_UA2);
        send_access(sio_cfg_pkg::OP_READ,  sio_cfg_pkg::PORT_DATA,  8'h00);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_UA1);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h9f);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_UB1);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h01);
    endtask

    // Floppy at secondary address is off; general config with kept bits;
    // a read carrying nonzero data must not write
    task automatic test_floppy_and_general();
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_FDC1);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h03);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, IX_GEN1);
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_DATA,  8'h00);
        send_access(sio_cfg_pkg::OP_READ,  sio_cfg_pkg::PORT_INDEX, 8'hff);
    endtask

    // Mostly select-then-access sequences on mapped registers, some unmapped
    // indexes, and some lone accesses of any kind
    task automatic run_config_sequence();
        logic [7:0] idx;
        int         n;
        if ($urandom_range(0, 6) == 0)
        begin
            send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 14))
            0:       idx = IX_ID;
            1:       idx = IX_REV;
            2:       idx = IX_GEN1;
            3:       idx = IX_GEN2;
            4:       idx = IX_FDC1;
            5:       idx = IX_FDC2;
            6:       idx = IX_LPT1;
            7:       idx = IX_LPT2;
            8:       idx = IX_UA1;
            9:       idx = IX_UA2;
            10:      idx = IX_UB1;
            11:      idx = IX_UB2;
            12:      idx = IX_DISK;
            default: idx = 8'($urandom_range(0, 255));
        endcase
        send_access(sio_cfg_pkg::OP_WRITE, sio_cfg_pkg::PORT_INDEX, idx);
        n = $urandom_range(1, 4);
        repeat (n)
            send_access(($urandom_range(0, 9) < 7) ? sio_cfg_pkg::OP_WRITE
                                                   : sio_cfg_pkg::OP_READ,
                        ($urandom_range(0, 9) < 9) ? sio_cfg_pkg::PORT_DATA
                                                   : sio_cfg_pkg::PORT_INDEX,
                        8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        while (accesses_sent < RANDOM_ITEMS)
            run_config_sequence();
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_back_to_back();
        idle_on = 1'b0;
        while (accesses_sent < TOTAL_ITEMS)
            run_config_sequence();
    endtask

    // ------------------------------------------------------------ receiver

    // tready stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 5);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Every accepted result transaction is matched to the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t ns: result transaction with no access pending: 0x%0h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want_status = pending_status.pop_front();
                got_status.read_data     = m_axis_tdata[7:0];
                got_status.floppy_on     = m_axis_tdata[8];
                got_status.parallel_on   = m_axis_tdata[9];
                got_status.parallel_base = m_axis_tdata[19:10];
                got_status.uart_a_on     = m_axis_tdata[20];
                got_status.uart_a_base   = m_axis_tdata[30:21];
                got_status.uart_a_irq    = m_axis_tdata[33:31];
                got_status.uart_b_on     = m_axis_tdata[34];
                got_status.uart_b_base   = m_axis_tdata[44:35];
                got_status.uart_b_irq    = m_axis_tdata[47:45];
                compare_field("read_data", 10'(want_status.read_data),
                              10'(got_status.read_data));
                compare_field("floppy_on", 10'(want_status.floppy_on),
                              10'(got_status.floppy_on));
                compare_field("parallel_on", 10'(want_status.parallel_on),
                              10'(got_status.parallel_on));
                compare_field("parallel_base", want_status.parallel_base,
                              got_status.parallel_base);
                compare_field("uart_a_on", 10'(want_status.uart_a_on),
                              10'(got_status.uart_a_on));
                compare_field("uart_a_base", want_status.uart_a_base,
                              got_status.uart_a_base);
                compare_field("uart_a_irq", 10'(want_status.uart_a_irq),
                              10'(got_status.uart_a_irq));
                compare_field("uart_b_on", 10'(want_status.uart_b_on),
                              10'(got_status.uart_b_on));
                compare_field("uart_b_base", want_status.uart_b_base,
                              got_status.uart_b_base);
                compare_field("uart_b_irq", 10'(want_status.uart_b_irq),
                              10'(got_status.uart_b_irq));
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- main

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_id_and_revision();
        test_unknown_index();
        test_parallel_decode();
        test_serial_ports();
        test_floppy_and_general();
        test_random_traffic();
        test_back_to_back();
        s_axis_tvalid <= 1'b0;

        // drain, then keep waiting to catch stray results
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
